// ===== rtl/iucs_pkg.sv =====
// Package with constants and the ones'-complement adder for the IPv4/UDP checksum unit.
package iucs_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned IhlW  = 4;

  // Smallest last-byte offset that counts as long enough (length = offset + 1).
  localparam logic [WordW-1:0] HdrMinLastOff = 16'd19;
  localparam logic [WordW-1:0] UdpMinLastOff = 16'd27;
  localparam logic [WordW-1:0] HdrCsumOff    = 16'd10;
  localparam logic [WordW-1:0] ProtoWordOff  = 16'd8;
  localparam logic [WordW-1:0] SrcAddrHiOff  = 16'd12;
  localparam logic [WordW-1:0] SrcAddrLoOff  = 16'd14;
  localparam logic [WordW-1:0] DstAddrHiOff  = 16'd16;
  localparam logic [WordW-1:0] DstAddrLoOff  = 16'd18;
  localparam logic [WordW-1:0] UdpLenRelOff  = 16'd4;
  localparam logic [WordW-1:0] UdpCsumRelOff = 16'd6;
  localparam logic [WordW-1:0] CountSatLo    = 16'hfffe;

  // Ones'-complement add with end-around carry. The folded sum cannot carry again.
  function automatic logic [WordW-1:0] oc_add(input logic [WordW-1:0] acc,
                                               input logic [WordW-1:0] w);
    logic [WordW:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

endpackage

// ===== rtl/iucs_in_if.sv =====
// Input channel: one packet byte per word with an end-of-packet mark.
interface iucs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;

  modport source(output valid, packet_byte, last_byte, input ready);
  modport sink(input valid, packet_byte, last_byte, output ready);
endinterface

// ===== rtl/iucs_out_if.sv =====
// Output channel: both checksums of one packet and their length flags.
interface iucs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_sum;
  logic [15:0] udp_sum;
  logic        header_sum_valid;
  logic        udp_sum_valid;

  modport source(output valid, header_sum, udp_sum, header_sum_valid, udp_sum_valid,
                 input ready);
  modport sink(input valid, header_sum, udp_sum, header_sum_valid, udp_sum_valid,
               output ready);
endinterface

// ===== rtl/ipv4_udp_checksum_unit.sv =====
// IPv4 header and UDP checksum unit over a byte stream, with a registered result word.
//
//   channel | dir | word contents                                         | handshake
//   in_i    | in  | packet_byte, last_byte                                | valid/ready
//   out_o   | out | header_sum, udp_sum, header_sum_valid, udp_sum_valid  | valid/ready
//
// One byte is taken per cycle while in_i.ready is high; the accumulators update in the same cycle as the byte.
// The result for a packet appears in the cycle after its last byte is accepted.
// Reset clears the byte counter, both accumulators, the IHL register and the result valid.
// Input is stalled only while a finished result is held and not taken downstream.
module ipv4_udp_checksum_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  iucs_in_if.sink    in_i,
  iucs_out_if.source out_o
);
  import iucs_pkg::*;

  logic [WordW-1:0] byte_cnt_q, byte_cnt_d;
  logic [WordW-1:0] hdr_acc_q, hdr_acc_d;
  logic [WordW-1:0] udp_acc_q, udp_acc_d;
  logic [ByteW-1:0] pend_q;
  logic [IhlW-1:0]  ihl_q, ihl_d;

  logic             out_valid_q;
  logic [WordW-1:0] hdr_sum_q, udp_sum_q, hdr_sum_d, udp_sum_d;
  logic             hdr_valid_q, udp_valid_q, hdr_valid_d, udp_valid_d;

  logic             in_acc;
  logic             word_done;
  logic [WordW-1:0] word;
  logic [WordW-1:0] woff;
  logic [WordW-1:0] hlen;
  logic [WordW-1:0] hdr_add, udp_add_a, udp_add_b, udp_add_c;
  logic [WordW-1:0] hdr_new, udp_new;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    // The IHL nibble is live in the same cycle that byte 0 arrives.
    ihl_d     = (byte_cnt_q == '0) ? in_i.packet_byte[IhlW-1:0] : ihl_q;
    hlen      = {{(WordW-IhlW-2){1'b0}}, ihl_d, 2'b00};
    word_done = byte_cnt_q[0] || in_i.last_byte;
    // An odd final byte is the high half of a word padded with zero.
    word      = byte_cnt_q[0] ? {pend_q, in_i.packet_byte} : {in_i.packet_byte, 8'h00};
    woff      = {byte_cnt_q[WordW-1:1], 1'b0};

    hdr_add   = '0;
    udp_add_a = '0;
    udp_add_b = '0;
    udp_add_c = '0;
    if (word_done) begin
      if (woff < hlen && woff != HdrCsumOff) hdr_add = word;
      if (woff == SrcAddrHiOff || woff == SrcAddrLoOff ||
          woff == DstAddrHiOff || woff == DstAddrLoOff) begin
        udp_add_a = word;
      end else if (woff == ProtoWordOff) begin
        udp_add_a = {8'h00, word[ByteW-1:0]};
      end
      // The UDP length word is counted once for the pseudo-header and once as data.
      if (woff >= hlen) begin
        if (woff == hlen + UdpLenRelOff) begin
          udp_add_b = word;
          udp_add_c = word;
        end else if (woff != hlen + UdpCsumRelOff) begin
          udp_add_b = word;
        end
      end
    end
    // Adding zero leaves a ones'-complement sum unchanged, so idle terms are zero.
    hdr_new = oc_add(hdr_acc_q, hdr_add);
    udp_new = oc_add(oc_add(oc_add(udp_acc_q, udp_add_a), udp_add_b), udp_add_c);

    hdr_valid_d = byte_cnt_q >= HdrMinLastOff;
    udp_valid_d = byte_cnt_q >= UdpMinLastOff;
    hdr_sum_d   = hdr_valid_d ? ~hdr_new : '0;
    udp_sum_d   = udp_valid_d ? ~udp_new : '0;

    if (in_i.last_byte) begin
      byte_cnt_d = '0;
      hdr_acc_d  = '0;
      udp_acc_d  = '0;
    end else begin
      // Near the top the counter toggles its low bit so byte pairing goes on.
      byte_cnt_d = (byte_cnt_q >= CountSatLo) ? (byte_cnt_q ^ 16'd1)
                                              : (byte_cnt_q + 16'd1);
      hdr_acc_d  = hdr_new;
      udp_acc_d  = udp_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q  <= '0;
      hdr_acc_q   <= '0;
      udp_acc_q   <= '0;
      ihl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        byte_cnt_q <= byte_cnt_d;
        hdr_acc_q  <= hdr_acc_d;
        udp_acc_q  <= udp_acc_d;
        ihl_q      <= in_i.last_byte ? '0 : ihl_d;
      end
      if (in_acc && in_i.last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !byte_cnt_q[0]) pend_q <= in_i.packet_byte;
    if (in_acc && in_i.last_byte) begin
      hdr_sum_q   <= hdr_sum_d;
      udp_sum_q   <= udp_sum_d;
      hdr_valid_q <= hdr_valid_d;
      udp_valid_q <= udp_valid_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.header_sum       = hdr_sum_q;
  assign out_o.udp_sum          = udp_sum_q;
  assign out_o.header_sum_valid = hdr_valid_q;
  assign out_o.udp_sum_valid    = udp_valid_q;

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_byte |=> out_valid_q)
    else $error("accepted last byte did not produce a result");

  a_last_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_byte |=> byte_cnt_q == '0 && hdr_acc_q == '0 && udp_acc_q == '0)
    else $error("packet state not cleared after last byte");

  a_udp_implies_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && udp_valid_q |-> hdr_valid_q)
    else $error("UDP length flag set without header length flag");

  a_short_hdr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !hdr_valid_q |-> hdr_sum_q == '0)
    else $error("header sum not zero for short packet");

  a_short_udp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !udp_valid_q |-> udp_sum_q == '0)
    else $error("UDP sum not zero for short packet");

endmodule
